/* src/smx_pkg.sv */
// Shared opcodes, result kinds and controller/datapath interface types.
`default_nettype none
package smx_pkg;

    // Instruction codes
    localparam logic [4:0] OP_PUSH_VAR  = 5'd0;
    localparam logic [4:0] OP_PUSH_IMM  = 5'd1;
    localparam logic [4:0] OP_STORE     = 5'd2;
    localparam logic [4:0] OP_STORE_POP = 5'd3;
    localparam logic [4:0] OP_ADD       = 5'd4;
    localparam logic [4:0] OP_SUB       = 5'd5;
    localparam logic [4:0] OP_MUL       = 5'd6;
    localparam logic [4:0] OP_DIV       = 5'd7;
    localparam logic [4:0] OP_EQ        = 5'd11;
    localparam logic [4:0] OP_NE        = 5'd12;
    localparam logic [4:0] OP_GT        = 5'd13;
    localparam logic [4:0] OP_LT        = 5'd14;
    localparam logic [4:0] OP_GE        = 5'd15;
    localparam logic [4:0] OP_LE        = 5'd16;
    localparam logic [4:0] OP_AND       = 5'd17;
    localparam logic [4:0] OP_OR        = 5'd18;
    localparam logic [4:0] OP_NOT       = 5'd19;
    localparam logic [4:0] OP_INPUT     = 5'd20;
    localparam logic [4:0] OP_OUTPUT    = 5'd21;
    localparam logic [4:0] OP_STOP      = 5'd22;

    // Result kinds
    localparam logic [2:0] KIND_OUTPUT    = 3'd0;
    localparam logic [2:0] KIND_HALT      = 3'd1;
    localparam logic [2:0] KIND_UNDERFLOW = 3'd2;
    localparam logic [2:0] KIND_OVERFLOW  = 3'd3;
    localparam logic [2:0] KIND_DIV_ZERO  = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic       latch;
        logic       rd;
        logic       commit;
        logic       div_start;
        logic       div_commit;
        logic       clr_step;
        logic       out_load;
        logic [2:0] out_kind;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [4:0] op;
        logic       halted;
        logic       sp_empty;
        logic       sp_below2;
        logic       sp_full;
        logic       b_zero;
        logic       div_done;
        logic       clr_last;
        logic       out_free;
    } sts_t;

    // Two-operand instructions (second entry OP top entry)
    function automatic logic is_binary(input logic [4:0] op);
        logic r;
        case (op)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_NE, OP_GT, OP_LT,
            OP_GE, OP_LE, OP_AND, OP_OR: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/smx_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module smx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* src/smx_div.sv */
// Signed 32-bit divider, truncating, one quotient bit per cycle.
`default_nettype none
module smx_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output      logic        done,
    output      logic [31:0] quotient
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] mb_reg, mb_next;
    logic        neg_reg, neg_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;
    logic [33:0] diff;

    // one restoring step
    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = {1'b0, shifted} - {2'b00, mb_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend[31] ? (32'd0 - dividend) : dividend;
            mb_next   = divisor[31] ? (32'd0 - divisor) : divisor;
            neg_next  = dividend[31] ^ divisor[31];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[33])
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

endmodule
`default_nettype wire

/* src/smx_ctrl.sv */
// Instruction sequencer: clear pass, accept, read, execute, divide wait.
`default_nettype none
module smx_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire smx_pkg::sts_t sts,
    output      smx_pkg::cmd_t cmd,
    output      logic          ready
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_DIVIDE
    } state_t;

    state_t     state_reg, state_next;
    logic       err;
    logic       emit;
    logic [2:0] kind;

    // error and result classification of the latched instruction
    always_comb
    begin
        err  = 1'b0;
        emit = 1'b0;
        kind = smx_pkg::KIND_OUTPUT;
        case (sts.op)
            smx_pkg::OP_PUSH_VAR, smx_pkg::OP_PUSH_IMM:
            begin
                err  = sts.sp_full;
                kind = smx_pkg::KIND_OVERFLOW;
            end
            smx_pkg::OP_STORE, smx_pkg::OP_STORE_POP, smx_pkg::OP_NOT:
            begin
                err  = sts.sp_empty;
                kind = smx_pkg::KIND_UNDERFLOW;
            end
            smx_pkg::OP_OUTPUT:
            begin
                err  = sts.sp_empty;
                emit = 1'b1;
                kind = sts.sp_empty ? smx_pkg::KIND_UNDERFLOW : smx_pkg::KIND_OUTPUT;
            end
            smx_pkg::OP_STOP:
            begin
                emit = 1'b1;
                kind = smx_pkg::KIND_HALT;
            end
            default:
            begin
                if (smx_pkg::is_binary(sts.op))
                begin
                    if (sts.sp_below2)
                    begin
                        err  = 1'b1;
                        kind = smx_pkg::KIND_UNDERFLOW;
                    end
                    else if (sts.op == smx_pkg::OP_DIV && sts.b_zero)
                    begin
                        err  = 1'b1;
                        kind = smx_pkg::KIND_DIV_ZERO;
                    end
                end
            end
        endcase
        if (err)
        begin
            emit = 1'b1;
        end
    end

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.halted)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.op == smx_pkg::OP_DIV && !err)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVIDE;
                end
                else if (!emit || sts.out_free)
                begin
                    cmd.commit   = !err;
                    cmd.out_load = emit;
                    cmd.out_kind = kind;
                    state_next   = S_IDLE;
                end
            end
            S_DIVIDE:
            begin
                if (sts.div_done)
                begin
                    cmd.div_commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign ready = (state_reg == S_IDLE);

endmodule
`default_nettype wire

/* src/smx_dp.sv */
// Datapath: operand stack, variable store, ALU, divider and result register.
`default_nettype none
module smx_dp #(
    parameter int STACK_DEPTH = 64,
    parameter int VAR_COUNT   = 256
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire smx_pkg::cmd_t cmd,
    output      smx_pkg::sts_t sts,
    input  wire logic [4:0]    opcode,
    input  wire logic [7:0]    var_index,
    input  wire logic [31:0]   immediate,
    input  wire logic [31:0]   input_value,
    input  wire logic          out_stall,
    output      logic          out_valid,
    output      logic [2:0]    result_kind,
    output      logic [31:0]   result_value
);

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int VAW = $clog2(VAR_COUNT);
    // reciprocal of VAR_COUNT, exact for any 8-bit index
    localparam int VSH = 8 + $clog2(VAR_COUNT);
    localparam int VRM = ((1 << VSH) + VAR_COUNT - 1) / VAR_COUNT;

    logic [4:0]     op_reg;
    logic [VAW-1:0] vi_reg;
    logic [31:0]    imm_reg;
    logic [31:0]    inv_reg;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [31:0]    tos_reg, tos_next;
    logic           halted_reg;
    logic [VAW-1:0] clr_idx_reg;
    logic           out_valid_reg;
    logic [2:0]     kind_reg;
    logic [31:0]    value_reg;

    logic [SPW-1:0] sp_m1, sp_m2;
    logic           stk_we;
    logic [31:0]    stk_rdata;
    logic           var_we;
    logic [VAW-1:0] var_waddr;
    logic [31:0]    var_wdata;
    logic [31:0]    var_rdata;
    logic [31:0]    a, b, alu_r, prod;
    logic           div_done;
    logic [31:0]    div_q;
    logic           is_push;
    logic [31:0]    vi_prod;
    logic [31:0]    vi_quo;
    logic [31:0]    vi_mod;

    assign sp_m1   = sp_reg - SPW'(1);
    assign sp_m2   = sp_reg - SPW'(2);
    assign a       = stk_rdata;
    assign b       = tos_reg;
    assign is_push = (op_reg == smx_pkg::OP_PUSH_VAR) || (op_reg == smx_pkg::OP_PUSH_IMM);

    // variable index modulo VAR_COUNT by reciprocal multiply
    assign vi_prod = 32'(var_index) * 32'(VRM);
    assign vi_quo  = vi_prod >> VSH;
    assign vi_mod  = 32'(var_index) - vi_quo * 32'(VAR_COUNT);

    // entries below the top of stack live in RAM; the top stays in tos_reg
    assign stk_we = cmd.commit && is_push && (sp_reg != '0);

    smx_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (sp_m1[SAW-1:0]),
        .wdata (tos_reg),
        .re    (cmd.rd),
        .raddr (sp_m2[SAW-1:0]),
        .rdata (stk_rdata)
    );

    // variable store: clearing sweep or instruction write
    always_comb
    begin
        var_we    = 1'b0;
        var_waddr = vi_reg;
        var_wdata = tos_reg;
        if (cmd.clr_step)
        begin
            var_we    = 1'b1;
            var_waddr = clr_idx_reg;
            var_wdata = '0;
        end
        else if (cmd.commit)
        begin
            var_we = (op_reg == smx_pkg::OP_STORE) || (op_reg == smx_pkg::OP_STORE_POP)
                  || (op_reg == smx_pkg::OP_INPUT);
            if (op_reg == smx_pkg::OP_INPUT)
            begin
                var_wdata = inv_reg;
            end
        end
    end

    smx_ram #(
        .WIDTH (32),
        .DEPTH (VAR_COUNT)
    ) u_vars (
        .clk   (clk),
        .we    (var_we),
        .waddr (var_waddr),
        .wdata (var_wdata),
        .re    (cmd.rd),
        .raddr (vi_reg),
        .rdata (var_rdata)
    );

    smx_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (a),
        .divisor  (b),
        .done     (div_done),
        .quotient (div_q)
    );

    // two-operand ALU, a is second entry, b is top
    assign prod = a * b;

    always_comb
    begin
        case (op_reg)
            smx_pkg::OP_ADD: alu_r = a + b;
            smx_pkg::OP_SUB: alu_r = a - b;
            smx_pkg::OP_MUL: alu_r = prod;
            smx_pkg::OP_EQ:  alu_r = {31'd0, a == b};
            smx_pkg::OP_NE:  alu_r = {31'd0, a != b};
            smx_pkg::OP_GT:  alu_r = {31'd0, $signed(a) > $signed(b)};
            smx_pkg::OP_LT:  alu_r = {31'd0, $signed(a) < $signed(b)};
            smx_pkg::OP_GE:  alu_r = {31'd0, $signed(a) >= $signed(b)};
            smx_pkg::OP_LE:  alu_r = {31'd0, $signed(a) <= $signed(b)};
            smx_pkg::OP_AND: alu_r = {31'd0, (a != '0) && (b != '0)};
            smx_pkg::OP_OR:  alu_r = {31'd0, (a != '0) || (b != '0)};
            default:         alu_r = '0;
        endcase
    end

    // stack pointer and top-of-stack update
    always_comb
    begin
        tos_next = tos_reg;
        sp_next  = sp_reg;
        if (cmd.commit)
        begin
            case (op_reg)
                smx_pkg::OP_PUSH_VAR:
                begin
                    tos_next = var_rdata;
                    sp_next  = sp_reg + SPW'(1);
                end
                smx_pkg::OP_PUSH_IMM:
                begin
                    tos_next = imm_reg;
                    sp_next  = sp_reg + SPW'(1);
                end
                smx_pkg::OP_STORE_POP, smx_pkg::OP_OUTPUT:
                begin
                    tos_next = stk_rdata;
                    sp_next  = sp_m1;
                end
                smx_pkg::OP_NOT:
                begin
                    tos_next = {31'd0, tos_reg == '0};
                end
                default:
                begin
                    if (smx_pkg::is_binary(op_reg))
                    begin
                        tos_next = alu_r;
                        sp_next  = sp_m1;
                    end
                end
            endcase
        end
        else if (cmd.div_commit)
        begin
            tos_next = div_q;
            sp_next  = sp_m1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            halted_reg    <= 1'b0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg <= sp_next;
            if (cmd.commit && op_reg == smx_pkg::OP_STOP)
            begin
                halted_reg <= 1'b1;
            end
            if (cmd.clr_step)
            begin
                clr_idx_reg <= clr_idx_reg + VAW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
        if (cmd.latch)
        begin
            op_reg  <= opcode;
            vi_reg  <= VAW'(vi_mod);
            imm_reg <= immediate;
            inv_reg <= input_value;
        end
        if (cmd.out_load)
        begin
            kind_reg  <= cmd.out_kind;
            value_reg <= (cmd.out_kind == smx_pkg::KIND_OUTPUT) ? tos_reg : '0;
        end
    end

    always_comb
    begin
        sts           = '0;
        sts.op        = op_reg;
        sts.halted    = halted_reg;
        sts.sp_empty  = (sp_reg == '0);
        sts.sp_below2 = (sp_reg < SPW'(2));
        sts.sp_full   = (sp_reg == SPW'(STACK_DEPTH));
        sts.b_zero    = (tos_reg == '0);
        sts.div_done  = div_done;
        sts.clr_last  = (clr_idx_reg == VAW'(VAR_COUNT - 1));
        sts.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign result_value = value_reg;

endmodule
`default_nettype wire

/* src/stack_machine_executor.sv */
// Stack-machine executor: one instruction per input transaction, optional result
// transaction. After reset the block sweeps the variable store to zero, one entry per
// cycle, through all VAR_COUNT entries, and holds in_stall high meanwhile. Each
// instruction then passes accept, stack and variable RAM read, and execute and write back;
// the read step is there for the registered read of the stack and variable RAMs. A divide
// adds a wait on the one-bit-per-cycle divider. An instruction with a result waits in
// execute while an earlier result still sits stalled in the output register. After stop,
// instructions are accepted and dropped until reset.
`default_nettype none
module stack_machine_executor #(
    parameter int STACK_DEPTH = 64,
    parameter int VAR_COUNT   = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic [4:0]  opcode,
    input  wire logic [7:0]  var_index,
    input  wire logic [31:0] immediate,
    input  wire logic [31:0] input_value,
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      logic [2:0]  result_kind,
    output      logic [31:0] result_value
);

    smx_pkg::cmd_t cmd;
    smx_pkg::sts_t sts;
    logic          ready;

    smx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd),
        .ready    (ready)
    );

    smx_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .VAR_COUNT   (VAR_COUNT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .opcode       (opcode),
        .var_index    (var_index),
        .immediate    (immediate),
        .input_value  (input_value),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .result_kind  (result_kind),
        .result_value (result_value)
    );

    assign in_stall = !ready;

endmodule
`default_nettype wire

/* src/smx_checker.sv */
// Port-level checks of the executor, bound to the top level.
`default_nettype none
module smx_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  result_kind,
    input wire logic [31:0] result_value
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_kind) && $stable(result_value))
        else $error("stalled result changed");

    // only an output transaction carries a value
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != smx_pkg::KIND_OUTPUT |-> result_value == '0)
        else $error("nonzero value on non-output result");

    // kind stays within the defined codes
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result_kind <= smx_pkg::KIND_DIV_ZERO)
        else $error("undefined result kind");

    // one instruction at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("accepted back to back");

    // nothing follows a delivered halt directly
    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && result_kind == smx_pkg::KIND_HALT |=> !out_valid)
        else $error("result after halt");

endmodule

bind stack_machine_executor smx_checker u_smx_checker (.*);
`default_nettype wire
